FILE: sv/kmct_pkg.sv
// ----------------------------------------------------------------------------
// kmct_pkg
// Shared sizes, status codes and entry types for the keyed minimum/count table.
// ----------------------------------------------------------------------------
package kmct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_BITS  = 16;
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 32;
    localparam int MIN_W       = 31;
    localparam int STATUS_W    = 3;
    localparam int INDEX_OUT_W = 4;
    localparam int COUNT_OUT_W = 16;

    // address into the store, and a position that can also hold the depth
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W  = $clog2(TABLE_DEPTH + 1);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUMP    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

    // input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    // one table entry
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [MIN_W-1:0]      minimum;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    // result of the shared compare/update unit
    typedef struct packed {
        logic                  match;
        logic [MIN_W-1:0]      minimum;
        logic [COUNT_BITS-1:0] count;
    } t_upd;

endpackage

FILE: sv/kmct_store.sv
// ----------------------------------------------------------------------------
// kmct_store
// Entry storage: one write port and one read port, no reset on contents.
// ----------------------------------------------------------------------------
module kmct_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [kmct_pkg::ADDR_W-1:0]   i_waddr,
    input  kmct_pkg::t_entry              i_wdata,
    input  logic [kmct_pkg::ADDR_W-1:0]   i_raddr,
    output kmct_pkg::t_entry              o_rdata
);
    import kmct_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // entry write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, data valid the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/kmct_alu.sv
// ----------------------------------------------------------------------------
// kmct_alu
// Shared compare/update unit: key match, running minimum, saturating count.
// ----------------------------------------------------------------------------
module kmct_alu (
    input  kmct_pkg::t_entry               i_entry,
    input  logic [kmct_pkg::KEY_W-1:0]     i_key,
    input  logic [kmct_pkg::MIN_W-1:0]     i_value,
    output kmct_pkg::t_upd                 o_upd
);
    import kmct_pkg::*;

    // key compare
    assign o_upd.match = (i_entry.key == i_key);

    // keep the smaller value
    assign o_upd.minimum = (i_entry.minimum > i_value) ? i_value : i_entry.minimum;

    // count bump, stuck at all ones
    assign o_upd.count = (&i_entry.count) ? i_entry.count
                                          : i_entry.count + COUNT_BITS'(1);

endmodule

FILE: sv/keyed_min_count_table.sv
// ----------------------------------------------------------------------------
// keyed_min_count_table
// Per-key minimum and count table with linear search and full dump.
// ----------------------------------------------------------------------------
// insert: one compare per cycle over the filled entries, result registered from
//   the compare that finds a match (update written there too) or reaches the fill level
// nonpositive insert and empty dump: result in the cycle after the transfer
// dump: one result per cycle, via the store read register and the result registers
// busy stays high until the final result; results cannot be stalled
// reset empties the table at once (fill level cleared, no clearing pass)
module keyed_min_count_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_action,
    input  logic [kmct_pkg::KEY_W-1:0]          i_key,
    input  logic signed [kmct_pkg::VALUE_W-1:0] i_sample_value,
    output logic                                o_strobe,
    output logic [kmct_pkg::STATUS_W-1:0]       o_status,
    output logic [kmct_pkg::INDEX_OUT_W-1:0]    o_entry_index,
    output logic [kmct_pkg::KEY_W-1:0]          o_entry_key,
    output logic [kmct_pkg::MIN_W-1:0]          o_entry_minimum,
    output logic [kmct_pkg::COUNT_OUT_W-1:0]    o_entry_count,
    output logic                                o_last
);
    import kmct_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DUMP   = 2'd2;

    logic [1:0]              r_state,  n_state;
    logic [POS_W-1:0]        r_idx,    n_idx;
    logic [POS_W-1:0]        r_fill,   n_fill;
    logic [KEY_W-1:0]        r_key,    n_key;
    logic [MIN_W-1:0]        r_val,    n_val;

    logic                    r_strobe, n_strobe;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [INDEX_OUT_W-1:0]  r_index,  n_index;
    logic [KEY_W-1:0]        r_okey,   n_okey;
    logic [MIN_W-1:0]        r_omin,   n_omin;
    logic [COUNT_OUT_W-1:0]  r_ocount, n_ocount;
    logic                    r_last,   n_last;

    logic                    accept;
    logic                    positive;
    logic                    we;
    logic [ADDR_W-1:0]       waddr;
    t_entry                  wdata;
    t_entry                  rdata;
    t_upd                    upd;

    // read address is n_idx rather than r_idx, so the registered rdata lines up with r_idx
    kmct_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    kmct_alu u_alu (
        .i_entry (rdata),
        .i_key   (r_key),
        .i_value (r_val),
        .o_upd   (upd)
    );

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign positive = (i_sample_value > 0);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_fill   = r_fill;
        n_key    = r_key;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_status = r_status;
        n_index  = r_index;
        n_okey   = r_okey;
        n_omin   = r_omin;
        n_ocount = r_ocount;
        n_last   = r_last;
        we       = 1'b0;
        waddr    = r_idx[ADDR_W-1:0];
        wdata    = '{key: r_key, minimum: upd.minimum, count: upd.count};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (i_action == ACT_DUMP) begin
                        if (r_fill == '0) begin
                            n_strobe = 1'b1;
                            n_status = ST_EMPTY;
                            n_index  = '0;
                            n_okey   = '0;
                            n_omin   = '0;
                            n_ocount = '0;
                            n_last   = 1'b1;
                        end else begin
                            n_state = S_DUMP;
                        end
                    end else if (!positive) begin
                        n_strobe = 1'b1;
                        n_status = ST_IGNORED;
                        n_index  = '0;
                        n_okey   = i_key;
                        n_omin   = '0;
                        n_ocount = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_key   = i_key;
                        n_val   = i_sample_value[MIN_W-1:0];
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_idx == r_fill) begin
                    // no match among filled entries
                    n_strobe = 1'b1;
                    n_okey   = r_key;
                    n_omin   = r_val;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    if (r_fill == POS_W'(TABLE_DEPTH)) begin
                        n_status = ST_FULL;
                        n_index  = '0;
                        n_ocount = '0;
                    end else begin
                        we       = 1'b1;
                        wdata    = '{key: r_key, minimum: r_val, count: COUNT_BITS'(1)};
                        n_fill   = r_fill + POS_W'(1);
                        n_status = ST_ADDED;
                        n_index  = INDEX_OUT_W'(r_idx);
                        n_ocount = COUNT_OUT_W'(1);
                    end
                end else if (upd.match) begin
                    we       = 1'b1;
                    n_strobe = 1'b1;
                    n_status = ST_UPDATED;
                    n_index  = INDEX_OUT_W'(r_idx);
                    n_okey   = r_key;
                    n_omin   = upd.minimum;
                    n_ocount = COUNT_OUT_W'(upd.count);
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + POS_W'(1);
                end
            end
            S_DUMP: begin
                n_strobe = 1'b1;
                n_status = ST_DUMP;
                n_index  = INDEX_OUT_W'(r_idx);
                n_okey   = rdata.key;
                n_omin   = rdata.minimum;
                n_ocount = COUNT_OUT_W'(rdata.count);
                n_last   = (r_idx + POS_W'(1) == r_fill);
                n_idx    = r_idx + POS_W'(1);
                if (r_idx + POS_W'(1) == r_fill) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_val    <= n_val;
        r_status <= n_status;
        r_index  <= n_index;
        r_okey   <= n_okey;
        r_omin   <= n_omin;
        r_ocount <= n_ocount;
        r_last   <= n_last;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_entry_index   = r_index;
    assign o_entry_key     = r_okey;
    assign o_entry_minimum = r_omin;
    assign o_entry_count   = r_ocount;
    assign o_last          = r_last;

    // fill level never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= POS_W'(TABLE_DEPTH))
        else $error("fill level beyond table depth");

    // a result that is not the last one belongs to a dump still running
    a_dump_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (busy && o_status == ST_DUMP))
        else $error("non-final result outside a dump");

    // an added entry grows the table by exactly one
    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_ADDED) |-> (r_fill == $past(r_fill) + POS_W'(1)))
        else $error("added entry without fill growth");

    // a positive insert transfer always starts a search
    a_insert_searches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_INSERT && positive) |=> (r_state == S_SEARCH))
        else $error("positive insert did not start a search");

endmodule
